### rtl/vmt_pkg.sv
// Shared types, register offsets and constants for the virtio-mmio register transport.
package vmt_pkg;

   localparam int unsigned QUEUE_DEPTH = 8;

   localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
   localparam logic [31:0] VERSION_WORD = 32'd2;
   localparam logic [31:0] ENTROPY_ID   = 32'd4;
   localparam logic [31:0] V1_WORD_MASK = 32'd1;
   localparam logic [31:0] DEPTH_WORD   = 32'(QUEUE_DEPTH);

   localparam logic [3:0] ST_ACK     = 4'h1;
   localparam logic [3:0] ST_DRV     = 4'h2;
   localparam logic [3:0] ST_DRV_OK  = 4'h4;
   localparam logic [3:0] ST_FEAT_OK = 4'h8;
   localparam logic [3:0] ST_ALL     = 4'hf;

   localparam logic [11:0] R_MAGIC     = 12'h000;
   localparam logic [11:0] R_VERSION   = 12'h004;
   localparam logic [11:0] R_DEVID     = 12'h008;
   localparam logic [11:0] R_VENDOR    = 12'h00c;
   localparam logic [11:0] R_DFEAT     = 12'h010;
   localparam logic [11:0] R_DFEAT_SEL = 12'h014;
   localparam logic [11:0] R_GFEAT     = 12'h020;
   localparam logic [11:0] R_GFEAT_SEL = 12'h024;
   localparam logic [11:0] R_QSEL      = 12'h030;
   localparam logic [11:0] R_QMAX      = 12'h034;
   localparam logic [11:0] R_QNUM      = 12'h038;
   localparam logic [11:0] R_QREADY    = 12'h044;
   localparam logic [11:0] R_QNOTIFY   = 12'h050;
   localparam logic [11:0] R_STATUS    = 12'h070;
   localparam logic [11:0] R_DESC_LO   = 12'h080;
   localparam logic [11:0] R_DESC_HI   = 12'h084;
   localparam logic [11:0] R_AVAIL_LO  = 12'h090;
   localparam logic [11:0] R_AVAIL_HI  = 12'h094;
   localparam logic [11:0] R_USED_LO   = 12'h0a0;
   localparam logic [11:0] R_USED_HI   = 12'h0a4;

   localparam logic [7:0] CSR_VENDOR_ID    = 8'd0;
   localparam logic [7:0] CSR_LAYOUT_DESC  = 8'd1;
   localparam logic [7:0] CSR_LAYOUT_AVAIL = 8'd2;
   localparam logic [7:0] CSR_LAYOUT_USED  = 8'd3;

   localparam logic [63:0] LAYOUT_DESC_RESET  = 64'd16384;
   localparam logic [63:0] LAYOUT_AVAIL_RESET = 64'd20480;
   localparam logic [63:0] LAYOUT_USED_RESET  = 64'd24576;

   typedef enum logic {
      MODE_READ  = 1'b0,
      MODE_WRITE = 1'b1
   } mode_type;

   typedef struct packed {
      logic        mode;
      logic [11:0] offset;
      logic [31:0] write_data;
   } access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        doorbell;
   } result_type;

   typedef struct packed {
      logic [31:0] vendor_id;
      logic [63:0] layout_desc_addr;
      logic [63:0] layout_avail_addr;
      logic [63:0] layout_used_addr;
   } config_type;

   function automatic logic [63:0] set_half(input logic [63:0] old, input logic [31:0] v,
                                            input logic high);
      logic [63:0] res;
      res = high ? {v, old[31:0]} : {old[63:32], v};
      return res;
   endfunction

endpackage

### rtl/virtio_mmio_register_transport_top.sv
// An accepted access passes through the input register and then the result register, which
// drives rsp_; the core decodes it combinationally between the two.
// Throughput: one access per cycle; a held result stalls the input only while rsp_stall is high.
// Reset: synchronous, clears status, selectors, queue state and ring addresses;
// configuration registers return to vendor 0 and the default ring layout.
module virtio_mmio_register_transport_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [11:0] req_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_access_error,
   output logic        rsp_doorbell,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);
   import vmt_pkg::*;

   access_type req_access;
   access_type acc;
   logic       acc_valid;
   logic       can_push;
   logic       fire;
   result_type result;
   result_type rsp_result;
   config_type cfg_ff;

   assign req_access.mode       = req_mode;
   assign req_access.offset     = req_offset;
   assign req_access.write_data = req_write_data;

   assign fire      = acc_valid && can_push;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vendor_id         <= '0;
         cfg_ff.layout_desc_addr  <= LAYOUT_DESC_RESET;
         cfg_ff.layout_avail_addr <= LAYOUT_AVAIL_RESET;
         cfg_ff.layout_used_addr  <= LAYOUT_USED_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VENDOR_ID:    cfg_ff.vendor_id         <= csr_data[31:0];
            CSR_LAYOUT_DESC:  cfg_ff.layout_desc_addr  <= csr_data;
            CSR_LAYOUT_AVAIL: cfg_ff.layout_avail_addr <= csr_data;
            CSR_LAYOUT_USED:  cfg_ff.layout_used_addr  <= csr_data;
            default: ;
         endcase
      end
   end

   vmt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_access (req_access),
      .take       (can_push),
      .acc_valid  (acc_valid),
      .acc        (acc)
   );

   vmt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .acc    (acc),
      .cfg    (cfg_ff),
      .result (result)
   );

   vmt_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .result     (result),
      .can_push   (can_push),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_read_data    = rsp_result.read_data;
   assign rsp_access_error = rsp_result.access_error;
   assign rsp_doorbell     = rsp_result.doorbell;
endmodule

### rtl/vmt_in_stage.sv
// Input register for register accesses.
module vmt_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  vmt_pkg::access_type req_access,
   input  logic                take,
   output logic                acc_valid,
   output vmt_pkg::access_type acc
);
   import vmt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   access_type acc_ff;

   assign req_stall = valid_ff && !take;
   assign valid_in  = (req_valid && !req_stall) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         acc_ff <= req_access;
      end
   end

   assign acc_valid = valid_ff;
   assign acc       = acc_ff;
endmodule

### rtl/vmt_core.sv
// Transport state and combinational decode of one register access.
module vmt_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  vmt_pkg::access_type acc,
   input  vmt_pkg::config_type cfg,
   output vmt_pkg::result_type result
);
   import vmt_pkg::*;

   logic [3:0]  status_ff, status_in;
   logic        dsel_one_ff, dsel_one_in;
   logic        gsel_ok_ff, gsel_ok_in;
   logic        gsel_bit_ff, gsel_bit_in;
   logic        w0_zero_ff, w0_zero_in;
   logic        w1_one_ff, w1_one_in;
   logic        qsel_zero_ff, qsel_zero_in;
   logic        size_set_ff, size_set_in;
   logic        ready_ff, ready_in;
   logic [63:0] desc_ff, desc_in;
   logic [63:0] avail_ff, avail_in;
   logic [63:0] used_ff, used_in;

   logic        layout_ok;
   logic        qlock;
   logic [31:0] v;
   logic [3:0]  st_acc;
   logic        ok;
   logic [31:0] rd;
   logic        bell;

   assign v         = acc.write_data;
   assign layout_ok = size_set_ff && (desc_ff == cfg.layout_desc_addr) &&
                      (avail_ff == cfg.layout_avail_addr) && (used_ff == cfg.layout_used_addr);
   assign qlock     = !qsel_zero_ff || ready_ff;

   always_comb begin
      status_in    = status_ff;
      dsel_one_in  = dsel_one_ff;
      gsel_ok_in   = gsel_ok_ff;
      gsel_bit_in  = gsel_bit_ff;
      w0_zero_in   = w0_zero_ff;
      w1_one_in    = w1_one_ff;
      qsel_zero_in = qsel_zero_ff;
      size_set_in  = size_set_ff;
      ready_in     = ready_ff;
      desc_in      = desc_ff;
      avail_in     = avail_ff;
      used_in      = used_ff;
      st_acc       = v[3:0];
      ok           = 1'b1;
      rd           = '0;
      bell         = 1'b0;
      if (acc.mode == MODE_READ) begin
         unique case (acc.offset)
            R_MAGIC:   rd = MAGIC_WORD;
            R_VERSION: rd = VERSION_WORD;
            R_DEVID:   rd = ENTROPY_ID;
            R_VENDOR:  rd = cfg.vendor_id;
            R_DFEAT:   rd = dsel_one_ff ? V1_WORD_MASK : '0;
            R_STATUS:  rd = {28'd0, status_ff};
            R_QMAX:    rd = qsel_zero_ff ? DEPTH_WORD : '0;
            R_QREADY:  rd = {31'd0, qsel_zero_ff && ready_ff};
            default:   ok = 1'b0;
         endcase
      end else begin
         unique case (acc.offset)
            R_DFEAT_SEL: dsel_one_in = (v == 32'd1);
            R_GFEAT_SEL: begin
               if ((status_ff & ST_FEAT_OK) != '0) begin
                  ok = 1'b0;
               end else begin
                  gsel_ok_in  = (v[31:1] == '0);
                  gsel_bit_in = v[0];
               end
            end
            R_GFEAT: begin
               if (((status_ff & ST_FEAT_OK) != '0) || !gsel_ok_ff) begin
                  ok = 1'b0;
               end else if (gsel_bit_ff) begin
                  w1_one_in = (v == V1_WORD_MASK);
               end else begin
                  w0_zero_in = (v == '0);
               end
            end
            R_QSEL: qsel_zero_in = (v == '0);
            R_QNUM: begin
               if (qlock || (v != DEPTH_WORD)) begin
                  ok = 1'b0;
               end else begin
                  size_set_in = 1'b1;
               end
            end
            R_DESC_LO, R_DESC_HI: begin
               if (qlock) begin
                  ok = 1'b0;
               end else begin
                  desc_in = set_half(desc_ff, v, acc.offset == R_DESC_HI);
               end
            end
            R_AVAIL_LO, R_AVAIL_HI: begin
               if (qlock) begin
                  ok = 1'b0;
               end else begin
                  avail_in = set_half(avail_ff, v, acc.offset == R_AVAIL_HI);
               end
            end
            R_USED_LO, R_USED_HI: begin
               if (qlock) begin
                  ok = 1'b0;
               end else begin
                  used_in = set_half(used_ff, v, acc.offset == R_USED_HI);
               end
            end
            R_QREADY: begin
               if (!qsel_zero_ff || (v[31:1] != '0)) begin
                  ok = 1'b0;
               end else if (!v[0]) begin
                  ready_in = 1'b0;
               end else if (!layout_ok) begin
                  ok = 1'b0;
               end else begin
                  ready_in = 1'b1;
               end
            end
            R_QNOTIFY: begin
               if ((v != '0) || (status_ff != ST_ALL) || !ready_ff) begin
                  ok = 1'b0;
               end else begin
                  bell = 1'b1;
               end
            end
            R_STATUS: begin
               if (v == '0) begin
                  status_in    = '0;
                  dsel_one_in  = 1'b0;
                  gsel_ok_in   = 1'b1;
                  gsel_bit_in  = 1'b0;
                  w0_zero_in   = 1'b1;
                  w1_one_in    = 1'b0;
                  qsel_zero_in = 1'b1;
                  size_set_in  = 1'b0;
                  ready_in     = 1'b0;
                  desc_in      = '0;
                  avail_in     = '0;
                  used_in      = '0;
               end else if ((v[31:4] != '0) || ((v[3:0] & status_ff) != status_ff)) begin
                  ok = 1'b0;
               end else begin
                  if (((v[3:0] & ST_FEAT_OK) != '0) && ((status_ff & ST_FEAT_OK) == '0)) begin
                     if ((v[3:0] & (ST_ACK | ST_DRV)) != (ST_ACK | ST_DRV) ||
                         !w0_zero_ff || !w1_one_ff) begin
                        st_acc = v[3:0] & ~ST_FEAT_OK;
                     end
                  end
                  if (((v[3:0] & ST_DRV_OK) != '0) && ((status_ff & ST_DRV_OK) == '0) &&
                      (((status_ff & ST_FEAT_OK) == '0) || !ready_ff || !layout_ok)) begin
                     ok = 1'b0;
                  end else begin
                     status_in = st_acc;
                  end
               end
            end
            default: ok = 1'b0;
         endcase
      end
      if (!ok) begin
         rd   = '0;
         bell = 1'b0;
      end
   end

   assign result.read_data    = rd;
   assign result.access_error = !ok;
   assign result.doorbell     = bell;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= '0;
         dsel_one_ff  <= 1'b0;
         gsel_ok_ff   <= 1'b1;
         gsel_bit_ff  <= 1'b0;
         w0_zero_ff   <= 1'b1;
         w1_one_ff    <= 1'b0;
         qsel_zero_ff <= 1'b1;
         size_set_ff  <= 1'b0;
         ready_ff     <= 1'b0;
         desc_ff      <= '0;
         avail_ff     <= '0;
         used_ff      <= '0;
      end else if (fire) begin
         status_ff    <= status_in;
         dsel_one_ff  <= dsel_one_in;
         gsel_ok_ff   <= gsel_ok_in;
         gsel_bit_ff  <= gsel_bit_in;
         w0_zero_ff   <= w0_zero_in;
         w1_one_ff    <= w1_one_in;
         qsel_zero_ff <= qsel_zero_in;
         size_set_ff  <= size_set_in;
         ready_ff     <= ready_in;
         desc_ff      <= desc_in;
         avail_ff     <= avail_in;
         used_ff      <= used_in;
      end
   end
endmodule

### rtl/vmt_out_stage.sv
// Result register for completed register accesses.
module vmt_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vmt_pkg::result_type result,
   output logic                can_push,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vmt_pkg::result_type rsp_result
);
   import vmt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_push = !valid_ff || !rsp_stall;
   assign valid_in = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
endmodule

### tb/tb_top.sv
// Self-checking testbench for the virtio-mmio register transport with random handshakes.
`timescale 1ns / 100ps

module tb_top;
   import vmt_pkg::*;

   typedef struct packed {
      mode_type    mode;
      logic [11:0] offset;
      logic [31:0] data;
      logic        fixed;
      result_type  res;
   } access_row;

   localparam result_type ACCEPTED = '0;
   localparam result_type REFUSED  = '{32'd0, 1'b1, 1'b0};

   localparam access_row DIRECTED [30] = '{
      '{MODE_READ,  R_MAGIC,     32'hffff_ffff, 1'b1, '{MAGIC_WORD, 1'b0, 1'b0}},
      '{MODE_READ,  R_VENDOR,    32'd0,         1'b1, ACCEPTED},
      '{MODE_READ,  R_QMAX,      32'd0,         1'b1, '{DEPTH_WORD, 1'b0, 1'b0}},
      '{MODE_READ,  12'hfff,     32'hffff_ffff, 1'b1, REFUSED},
      '{MODE_READ,  12'h002,     32'd0,         1'b1, REFUSED},
      '{MODE_READ,  R_DFEAT_SEL, 32'd0,         1'b1, REFUSED},
      '{MODE_WRITE, R_VERSION,   32'd0,         1'b1, REFUSED},
      '{MODE_WRITE, R_QNOTIFY,   32'd0,         1'b1, REFUSED},
      '{MODE_WRITE, R_STATUS,    32'h10,        1'b1, REFUSED},
      '{MODE_WRITE, R_DFEAT_SEL, 32'd1,         1'b1, ACCEPTED},
      '{MODE_READ,  R_DFEAT,     32'd0,         1'b1, '{V1_WORD_MASK, 1'b0, 1'b0}},
      '{MODE_WRITE, R_STATUS,    32'h1,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_STATUS,    32'h9,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_STATUS,    32'h3,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_GFEAT_SEL, 32'd1,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_GFEAT,     32'd1,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_STATUS,    32'hb,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_GFEAT,     32'd0,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_QNUM,      32'd7,         1'b1, REFUSED},
      '{MODE_WRITE, R_QNUM,      DEPTH_WORD,    1'b0, ACCEPTED},
      '{MODE_WRITE, R_QREADY,    32'd1,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_DESC_LO,   LAYOUT_DESC_RESET[31:0],  1'b0, ACCEPTED},
      '{MODE_WRITE, R_AVAIL_LO,  LAYOUT_AVAIL_RESET[31:0], 1'b0, ACCEPTED},
      '{MODE_WRITE, R_USED_LO,   LAYOUT_USED_RESET[31:0],  1'b0, ACCEPTED},
      '{MODE_WRITE, R_QREADY,    32'd2,         1'b1, REFUSED},
      '{MODE_WRITE, R_QREADY,    32'd1,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_STATUS,    32'hf,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_QNOTIFY,   32'd5,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_QNOTIFY,   32'd0,         1'b0, ACCEPTED},
      '{MODE_WRITE, R_STATUS,    32'h7,         1'b0, ACCEPTED}
   };

   localparam logic [11:0] REG_MAP [20] = '{
      R_MAGIC, R_VERSION, R_DEVID, R_VENDOR, R_DFEAT, R_DFEAT_SEL, R_GFEAT, R_GFEAT_SEL,
      R_QSEL, R_QMAX, R_QNUM, R_QREADY, R_QNOTIFY, R_STATUS, R_DESC_LO, R_DESC_HI,
      R_AVAIL_LO, R_AVAIL_HI, R_USED_LO, R_USED_HI
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [11:0] req_offset;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic        rsp_access_error;
   logic        rsp_doorbell;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [63:0] csr_data;

   virtio_mmio_register_transport_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_offset       (req_offset),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_access_error (rsp_access_error),
      .rsp_doorbell     (rsp_doorbell),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // transport state as the driver side sees it
   logic [31:0] cfg_vendor;
   logic [63:0] cfg_desc;
   logic [63:0] cfg_avail;
   logic [63:0] cfg_used;
   logic [3:0]  dev_status;
   logic [31:0] dev_feat_sel;
   logic [31:0] drv_feat_sel;
   logic [31:0] drv_feat_words [2];
   logic [31:0] queue_select;
   logic        size_set;
   logic        queue_ready;
   logic [63:0] desc_table;
   logic [63:0] avail_addr;
   logic [63:0] used_addr;

   result_type  awaited_results [$];
   logic        row_fixed;
   result_type  row_result;
   logic        calm;
   int          stall_left;
   int          cycle_count;
   int          n_sent;
   int          n_refused;
   int          n_rang;
   int          n_settings;
   int          mismatches;

   always #10 clock = ~clock;

   function automatic void clear_transport();
      dev_status        = '0;
      dev_feat_sel      = '0;
      drv_feat_sel      = '0;
      drv_feat_words[0] = '0;
      drv_feat_words[1] = '0;
      queue_select      = '0;
      size_set          = 1'b0;
      queue_ready       = 1'b0;
      desc_table        = '0;
      avail_addr        = '0;
      used_addr         = '0;
   endfunction

   function automatic logic layout_matches();
      return size_set && desc_table == cfg_desc && avail_addr == cfg_avail &&
             used_addr == cfg_used;
   endfunction

   function automatic result_type access_outcome(input access_type a);
      result_type  r;
      logic        ok;
      logic        lock;
      logic [31:0] v;
      logic [3:0]  keep;
      r    = '0;
      ok   = 1'b0;
      v    = a.write_data;
      lock = queue_select != 0 || queue_ready;
      if (a.mode == MODE_READ) begin
         ok = 1'b1;
         case (a.offset)
            R_MAGIC:   r.read_data = MAGIC_WORD;
            R_VERSION: r.read_data = VERSION_WORD;
            R_DEVID:   r.read_data = ENTROPY_ID;
            R_VENDOR:  r.read_data = cfg_vendor;
            R_DFEAT:   r.read_data = (dev_feat_sel == 32'd1) ? V1_WORD_MASK : '0;
            R_STATUS:  r.read_data = {28'd0, dev_status};
            R_QMAX:    r.read_data = (queue_select == 0) ? DEPTH_WORD : '0;
            R_QREADY:  r.read_data = {31'd0, queue_select == 0 && queue_ready};
            default:   ok = 1'b0;
         endcase
      end else begin
         case (a.offset)
            R_DFEAT_SEL: begin
               dev_feat_sel = v;
               ok = 1'b1;
            end
            R_GFEAT_SEL: if ((dev_status & ST_FEAT_OK) == 0) begin
               drv_feat_sel = v;
               ok = 1'b1;
            end
            R_GFEAT: if ((dev_status & ST_FEAT_OK) == 0 && drv_feat_sel < 2) begin
               drv_feat_words[drv_feat_sel[0]] = v;
               ok = 1'b1;
            end
            R_QSEL: begin
               queue_select = v;
               ok = 1'b1;
            end
            R_QNUM: if (!lock && v == DEPTH_WORD) begin
               size_set = 1'b1;
               ok = 1'b1;
            end
            R_DESC_LO, R_DESC_HI: if (!lock) begin
               if (a.offset == R_DESC_HI) desc_table[63:32] = v;
               else desc_table[31:0] = v;
               ok = 1'b1;
            end
            R_AVAIL_LO, R_AVAIL_HI: if (!lock) begin
               if (a.offset == R_AVAIL_HI) avail_addr[63:32] = v;
               else avail_addr[31:0] = v;
               ok = 1'b1;
            end
            R_USED_LO, R_USED_HI: if (!lock) begin
               if (a.offset == R_USED_HI) used_addr[63:32] = v;
               else used_addr[31:0] = v;
               ok = 1'b1;
            end
            R_QREADY: if (queue_select == 0 && v <= 1) begin
               if (v == 0) begin
                  queue_ready = 1'b0;
                  ok = 1'b1;
               end else if (layout_matches()) begin
                  queue_ready = 1'b1;
                  ok = 1'b1;
               end
            end
            R_QNOTIFY: if (v == 0 && dev_status == ST_ALL && queue_ready) begin
               r.doorbell = 1'b1;
               ok = 1'b1;
            end
            R_STATUS: begin
               if (v == 0) begin
                  clear_transport();
                  ok = 1'b1;
               end else if (v[31:4] == 0 && (v[3:0] & dev_status) == dev_status) begin
                  keep = v[3:0];
                  if ((keep & ST_FEAT_OK) != 0 && (dev_status & ST_FEAT_OK) == 0 &&
                      ((keep & (ST_ACK | ST_DRV)) != (ST_ACK | ST_DRV) ||
                       drv_feat_words[0] != 0 || drv_feat_words[1] != V1_WORD_MASK))
                     keep = keep & ~ST_FEAT_OK;
                  if ((v[3:0] & ST_DRV_OK) != 0 && (dev_status & ST_DRV_OK) == 0 &&
                      ((dev_status & ST_FEAT_OK) == 0 || !queue_ready || !layout_matches()))
                     ok = 1'b0;
                  else begin
                     dev_status = keep;
                     ok = 1'b1;
                  end
               end
            end
            default: ok = 1'b0;
         endcase
      end
      if (!ok) begin
         r.read_data = '0;
         r.doorbell  = 1'b0;
      end
      r.access_error = !ok;
      return r;
   endfunction

   function automatic logic [11:0] pick_offset();
      if ($urandom_range(0, 99) < 85) return REG_MAP[$urandom_range(0, 19)];
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 15);
         4:       return 32'hffff_ffff;
         5:       return DEPTH_WORD;
         6:       return ($urandom_range(0, 1) != 0) ? cfg_desc[31:0] : cfg_used[63:32];
         default: return '0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_access(input mode_type m, input logic [11:0] off, input logic [31:0] d,
                              input logic fixed, input result_type fres);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       = m;
      req_offset     = off;
      req_write_data = d;
      row_fixed      = fixed;
      row_result     = fres;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   // occasionally spoil a setup step
   task automatic setup_item(input mode_type m, input logic [11:0] off, input logic [31:0] d);
      if ($urandom_range(0, 24) == 0) begin
         case ($urandom_range(0, 2))
            0:       d = $urandom;
            1:       off = pick_offset();
            default: m = mode_type'(~m);
         endcase
      end
      send_access(m, off, d, 1'b0, ACCEPTED);
   endtask

   task automatic random_mix(input int target);
      int start;
      int n;
      int k;
      start = n_sent;
      while (n_sent - start < target) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 4) != 0) setup_item(MODE_WRITE, R_STATUS, '0);
            setup_item(MODE_WRITE, R_STATUS, 32'(ST_ACK));
            setup_item(MODE_WRITE, R_STATUS, 32'(ST_ACK | ST_DRV));
            setup_item(MODE_WRITE, R_DFEAT_SEL, $urandom_range(0, 2));
            setup_item(MODE_READ, R_DFEAT, $urandom);
            setup_item(MODE_WRITE, R_GFEAT_SEL, '0);
            setup_item(MODE_WRITE, R_GFEAT, ($urandom_range(0, 4) == 0) ? pick_data() : '0);
            setup_item(MODE_WRITE, R_GFEAT_SEL, 32'd1);
            setup_item(MODE_WRITE, R_GFEAT,
                       ($urandom_range(0, 4) == 0) ? pick_data() : V1_WORD_MASK);
            setup_item(MODE_WRITE, R_STATUS, 32'(ST_ACK | ST_DRV | ST_FEAT_OK));
            setup_item(MODE_READ, R_STATUS, $urandom);
            setup_item(MODE_WRITE, R_QSEL, ($urandom_range(0, 9) == 0) ? pick_data() : '0);
            setup_item(MODE_READ, R_QMAX, $urandom);
            setup_item(MODE_WRITE, R_QNUM, DEPTH_WORD);
            setup_item(MODE_WRITE, R_DESC_LO, cfg_desc[31:0]);
            setup_item(MODE_WRITE, R_DESC_HI, cfg_desc[63:32]);
            setup_item(MODE_WRITE, R_AVAIL_LO, cfg_avail[31:0]);
            setup_item(MODE_WRITE, R_AVAIL_HI, cfg_avail[63:32]);
            setup_item(MODE_WRITE, R_USED_LO, cfg_used[31:0]);
            setup_item(MODE_WRITE, R_USED_HI, cfg_used[63:32]);
            setup_item(MODE_WRITE, R_QREADY, 32'd1);
            setup_item(MODE_READ, R_QREADY, $urandom);
            setup_item(MODE_WRITE, R_STATUS, 32'(ST_ALL));
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
               setup_item(MODE_WRITE, R_QNOTIFY, '0);
               if ($urandom_range(0, 1) != 0) setup_item(MODE_READ, pick_offset(), $urandom);
            end
            if ($urandom_range(0, 3) == 0) setup_item(MODE_WRITE, R_QREADY, '0);
         end else begin
            n = $urandom_range(1, 20);
            for (k = 0; k < n; k++)
               send_access(mode_type'($urandom_range(0, 1)), pick_offset(), pick_data(),
                           1'b0, ACCEPTED);
         end
      end
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_VENDOR_ID:    cfg_vendor = value[31:0];
         CSR_LAYOUT_DESC:  cfg_desc   = value;
         CSR_LAYOUT_AVAIL: cfg_avail  = value;
         CSR_LAYOUT_USED:  cfg_used   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // accept side: predict every item taken by the block
   always @(posedge clock) begin
      result_type got;
      if (!reset && req_valid && !req_stall) begin
         got = access_outcome('{req_mode, req_offset, req_write_data});
         n_refused += got.access_error;
         n_rang    += got.doorbell;
         awaited_results.push_back(row_fixed ? row_result : got);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected item: read_data %h error %b doorbell %b", $time,
                     rsp_read_data, rsp_access_error, rsp_doorbell);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                        rsp_read_data);
               mismatches++;
            end
            if (rsp_access_error !== want.access_error) begin
               $display("%0t: access_error expected %b actual %b", $time, want.access_error,
                        rsp_access_error);
               mismatches++;
            end
            if (rsp_doorbell !== want.doorbell) begin
               $display("%0t: doorbell expected %b actual %b", $time, want.doorbell,
                        rsp_doorbell);
               mismatches++;
            end
         end
      end
   end

   // result side back-pressure, with calm stretches
   always @(negedge clock) begin
      cycle_count++;
      if (cycle_count % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      if (reset) rsp_stall = 1'b0;
      else if (stall_left != 0) stall_left--;
      else if (calm || $urandom_range(0, 99) < 60) begin
         rsp_stall  = 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall  = 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      end
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int i;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = 1'b0;
      req_offset     = '0;
      req_write_data = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      row_fixed      = 1'b0;
      row_result     = '0;
      calm           = 1'b0;
      stall_left     = 0;
      cycle_count    = 0;
      n_sent         = 0;
      n_refused      = 0;
      n_rang         = 0;
      n_settings     = 1;
      mismatches     = 0;
      cfg_vendor     = '0;
      cfg_desc       = LAYOUT_DESC_RESET;
      cfg_avail      = LAYOUT_AVAIL_RESET;
      cfg_used       = LAYOUT_USED_RESET;
      clear_transport();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < 30; i++)
         send_access(DIRECTED[i].mode, DIRECTED[i].offset, DIRECTED[i].data,
                     DIRECTED[i].fixed, DIRECTED[i].res);
      random_mix(240);

      settle();
      csr_write(CSR_VENDOR_ID, 64'hffff_ffff_ffff_ffff);
      csr_write(CSR_LAYOUT_DESC, '0);
      csr_write(CSR_LAYOUT_AVAIL, '0);
      csr_write(CSR_LAYOUT_USED, '0);
      n_settings++;
      random_mix(240);

      settle();
      csr_write(CSR_VENDOR_ID, '0);
      csr_write(CSR_LAYOUT_DESC, 64'hffff_ffff_ffff_ffff);
      csr_write(CSR_LAYOUT_AVAIL, 64'hffff_ffff_ffff_ffff);
      csr_write(CSR_LAYOUT_USED, 64'hffff_ffff_ffff_ffff);
      n_settings++;
      random_mix(240);

      settle();
      csr_write(CSR_VENDOR_ID, {$urandom, $urandom});
      csr_write(CSR_LAYOUT_DESC, {$urandom, $urandom});
      csr_write(CSR_LAYOUT_AVAIL, {$urandom, $urandom});
      csr_write(CSR_LAYOUT_USED, {$urandom, $urandom});
      n_settings++;
      random_mix(200);

      settle();
      repeat (8) @(negedge clock);
      $display("Drove %0d register accesses over %0d layout/vendor settings.", n_sent,
               n_settings);
      $display("%0d accesses refused, %0d doorbells rung, %0d mismatches.", n_refused,
               n_rang, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
rtl/vmt_pkg.sv
rtl/vmt_in_stage.sv
rtl/vmt_core.sv
rtl/vmt_out_stage.sv
rtl/virtio_mmio_register_transport_top.sv
tb/tb_top.sv
